// ===== hdl/crlfmd_pkg.sv =====
`timescale 1ns / 1ps

package crlfmd_pkg;

    // Fixed field widths of the byte and result channels.
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CAP_W    = 13;
    localparam int unsigned OFFSET_W = 12;
    localparam int unsigned LENGTH_W = 12;

    // Default buffer size and the capacity register value after reset.
    localparam int unsigned MAX_BUFFER_BYTES_DEF = 4096;
    localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

    // Framing characters.
    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_DATA      = 3'd0,
        ST_END       = 3'd1,
        ST_PEER_TERM = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_DONE      = 3'd4,
        ST_FAILED    = 3'd5,
        ST_LINK      = 3'd6
    } t_status;

    // One received item.
    typedef struct packed {
        logic              link_error;
        logic [BYTE_W-1:0] rx_byte;
    } t_rx_item;

    // One result item.
    typedef struct packed {
        logic [LENGTH_W-1:0] message_length;
        logic [OFFSET_W-1:0] byte_offset;
        logic [BYTE_W-1:0]   data_byte;
        logic                byte_valid;
        t_status             status;
    } t_result;

    // Sticky condition flags of the parser.
    typedef struct packed {
        logic done;
        logic failed;
    } t_flags;

endpackage

// ===== hdl/crlfmd_stage.sv =====
`timescale 1ns / 1ps

module crlfmd_stage
    import crlfmd_pkg::*;
#(
    parameter int unsigned WIDTH = $bits(t_result)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    logic             r_valid;
    logic [WIDTH-1:0] r_data;

    // The stage takes a new transfer when empty or when its content leaves now.
    assign o_ready = !r_valid || i_ready;

    // Valid flag of the stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload register; no reset needed.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hdl/crlfmd_parser.sv =====
`timescale 1ns / 1ps

module crlfmd_parser
    import crlfmd_pkg::*;
#(
    parameter int unsigned MAX_BUFFER_BYTES = MAX_BUFFER_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  t_rx_item         i_item,
    input  logic [CAP_W-1:0] i_capacity,
    output t_result          o_result,
    output t_flags           o_flags
);

    localparam int unsigned CNT_W = $clog2(MAX_BUFFER_BYTES + 1);
    localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_BUFFER_BYTES);

    logic             r_prev_was_cr;
    logic [CNT_W-1:0] r_byte_count;
    logic             r_input_done;
    logic             r_input_failed;

    logic             n_prev_was_cr;
    logic [CNT_W-1:0] n_byte_count;
    logic             n_input_done;
    logic             n_input_failed;

    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] cap_eff;
    logic [CMP_W-1:0] count_ext;

    // Capacity above the buffer size acts as the buffer size.
    always_comb begin
        cap_ext   = CMP_W'(i_capacity);
        cap_eff   = (cap_ext > MAX_CMP) ? MAX_CMP : cap_ext;
        count_ext = CMP_W'(r_byte_count);
    end

    // Result and next state for the byte at the head of the pipeline.
    always_comb begin
        n_prev_was_cr  = r_prev_was_cr;
        n_byte_count   = r_byte_count;
        n_input_done   = r_input_done;
        n_input_failed = r_input_failed;
        o_result       = '0;
        o_result.status = ST_DATA;

        priority if (r_input_done) begin
            o_result.status = ST_DONE;
        end else if (r_input_failed) begin
            o_result.status = ST_FAILED;
        end else if (count_ext >= cap_eff) begin
            o_result.status = ST_OVERFLOW;
            n_input_failed  = 1'b1;
        end else if (i_item.link_error) begin
            o_result.status = ST_LINK;
            n_input_failed  = 1'b1;
        end else begin
            o_result.byte_valid  = 1'b1;
            o_result.data_byte   = i_item.rx_byte;
            o_result.byte_offset = OFFSET_W'(r_byte_count);
            if (r_prev_was_cr && (i_item.rx_byte == CH_LF)) begin
                // CR LF closes the message; a lone CR LF marks peer termination and sets done.
                n_byte_count  = '0;
                n_prev_was_cr = 1'b0;
                if (r_byte_count == CNT_W'(1)) begin
                    o_result.status = ST_PEER_TERM;
                    n_input_done    = 1'b1;
                end else begin
                    o_result.status         = ST_END;
                    o_result.message_length = LENGTH_W'(r_byte_count - CNT_W'(1));
                end
            end else begin
                n_byte_count    = r_byte_count + CNT_W'(1);
                n_prev_was_cr   = (i_item.rx_byte == CH_CR);
                o_result.status = ST_DATA;
            end
        end
    end

    // Framing state advances once per byte passed to the output stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_was_cr  <= 1'b0;
            r_byte_count   <= '0;
            r_input_done   <= 1'b0;
            r_input_failed <= 1'b0;
        end else if (i_step) begin
            r_prev_was_cr  <= n_prev_was_cr;
            r_byte_count   <= n_byte_count;
            r_input_done   <= n_input_done;
            r_input_failed <= n_input_failed;
        end
    end

    assign o_flags.done   = r_input_done;
    assign o_flags.failed = r_input_failed;

endmodule

// ===== hdl/crlf_message_deframer_core.sv =====
`timescale 1ns / 1ps
// CR LF message deframer.
// Received bytes enter on the s_axis channel, one transfer per byte, with
// tuser set when the link failed instead of giving a byte. Each byte yields
// exactly one result transfer on m_axis: a status code in tuser, and in
// tdata the byte, its offset in the receive buffer and, at message end, the
// payload length. The buffer capacity register is written through
// i_cfg_wr_en / i_cfg_wr_data, only while no bytes are in flight; the
// user must keep to this, the block itself does not enforce it. Each byte
// passes an input register and a result register with the parser logic between.
// Throughput is one byte per cycle while results are taken; the framing
// state update is a single compare and increment as a byte enters the
// result register. Reset clears the framing state and the sticky done and
// failed flags, empties both registers and sets the capacity to 4096.
// When the receiver holds i_m_axis_tready low, the result register holds its
// transfer, the input register fills, and o_s_axis_tready falls; no byte is
// lost and the flow resumes at full rate once the receiver takes data.
module crlf_message_deframer_core
    import crlfmd_pkg::*;
#(
    parameter int unsigned MAX_BUFFER_BYTES = MAX_BUFFER_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Configuration: buffer capacity.
    input  logic             i_cfg_wr_en,
    input  logic [CAP_W-1:0] i_cfg_wr_data,
    // Received bytes.
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [7:0]       i_s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]       i_s_axis_tuser,   // [0] link_error
    // Results.
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,   // [7:0] data_byte, [19:8] byte_offset,
                                               // [31:20] message_length
    output logic [3:0]       o_m_axis_tuser    // [2:0] status, [3] byte_valid
);

    logic [CAP_W-1:0] r_buffer_capacity;

    t_rx_item in_item;
    t_rx_item head_item;
    logic     head_valid;
    logic     out_ready;
    logic     step;
    t_result  step_result;
    t_result  out_result;
    t_flags   flags;

    // Capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_capacity <= CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_buffer_capacity <= i_cfg_wr_data;
        end
    end

    assign in_item.rx_byte    = i_s_axis_tdata;
    assign in_item.link_error = i_s_axis_tuser[0];

    // Input register.
    crlfmd_stage #(
        .WIDTH ($bits(t_rx_item))
    ) u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (in_item),
        .o_valid (head_valid),
        .i_ready (out_ready),
        .o_data  (head_item)
    );

    // A byte is parsed when it moves from the input to the result register.
    assign step = head_valid && out_ready;

    crlfmd_parser #(
        .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_item     (head_item),
        .i_capacity (r_buffer_capacity),
        .o_result   (step_result),
        .o_flags    (flags)
    );

    // Result register.
    crlfmd_stage #(
        .WIDTH ($bits(t_result))
    ) u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .o_ready (out_ready),
        .i_data  (step_result),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (out_result)
    );

    assign o_m_axis_tdata = {out_result.message_length, out_result.byte_offset,
                             out_result.data_byte};
    assign o_m_axis_tuser = {out_result.byte_valid, out_result.status};

`ifndef SYNTHESIS
    // Done and failed are sticky.
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        flags.done |=> flags.done)
        else $error("done flag cleared");

    a_failed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        flags.failed |=> flags.failed)
        else $error("failed flag cleared");

    // Only one terminal condition can ever be reached.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(flags.done && flags.failed))
        else $error("done and failed both set");

    // A stored byte comes only with a data, message end or peer terminate status.
    a_byte_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[3]) |->
        (o_m_axis_tuser[2:0] == ST_DATA || o_m_axis_tuser[2:0] == ST_END ||
         o_m_axis_tuser[2:0] == ST_PEER_TERM))
        else $error("byte stored with an error status");
`endif

endmodule
